/* src/vme_pkg.sv */
// Shared types and constants for the voice command to MIDI event encoder.
package vme_pkg;

  localparam int VME_NUM_VOICES = 11;
  localparam int VME_QUEUE_DEPTH = 4;
  localparam int VME_DELTA_W = 28;

  localparam logic [7:0] VME_NO_NOTE = 8'hFF;
  localparam logic [6:0] VME_DEFAULT_LEVEL = 7'd80;

  typedef enum logic [2:0] {
    OP_KEY_ON     = 3'd0,
    OP_KEY_OFF    = 3'd1,
    OP_VOLUME     = 3'd2,
    OP_PAN        = 3'd3,
    OP_INSTRUMENT = 3'd4,
    OP_PITCH      = 3'd5,
    OP_DRUMSET    = 3'd6,
    OP_PERC_MODE  = 3'd7
  } vme_op_e;

  // one channel message: status, first data byte, optional second data byte
  typedef struct packed {
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
    logic       three;
  } vme_msg_t;

  // work for the serializer: delta ahead of the first message, up to three messages
  typedef struct packed {
    logic [VME_DELTA_W-1:0] delta;
    logic [1:0]             nmsg_m1;
    vme_msg_t [2:0]         msg;
  } vme_desc_t;

endpackage

/* src/vme_front.sv */
// Front end: takes voice commands, keeps voice state and builds message lists.
module vme_front import vme_pkg::*; #(
  parameter int NUM_VOICES = VME_NUM_VOICES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [6:0]             cfg_wr_data,
  input  logic                   accept,
  input  logic [2:0]             op,
  input  logic [3:0]             voice,
  input  logic [6:0]             note,
  input  logic signed [15:0]     amount,
  input  logic signed [7:0]      pan_value,
  input  logic [7:0]             bank,
  input  logic [6:0]             program_req,
  input  logic                   percussion_on,
  input  logic [VME_DELTA_W-1:0] delta_time,
  output logic                   push,
  output vme_desc_t              desc
);

  localparam int IDX_W = $clog2(NUM_VOICES);

  logic [7:0]             held_note [NUM_VOICES];
  logic [6:0]             perc_level [NUM_VOICES];
  logic                   perc_mode;
  logic [VME_DELTA_W-1:0] pending_delta;
  logic [6:0]             default_level;

  logic [IDX_W-1:0]       idx;
  logic                   vok;
  logic                   perc_hi;
  logic                   perc_mid;
  logic [3:0]             ch;
  logic [VME_DELTA_W:0]   dsum;
  logic [VME_DELTA_W-1:0] delta;
  logic [7:0]             held_rd;
  logic [6:0]             level_rd;
  logic [6:0]             note_c;
  logic [6:0]             vol;
  logic [6:0]             pan_p;
  logic [7:0]             pitch_u;
  logic [7:0]             key_s;
  logic [7:0]             ctrl_s;
  logic [1:0]             nmsg;
  logic                   held_we;
  logic [7:0]             held_wval;
  logic                   level_we;
  logic                   mode_we;

  function automatic vme_msg_t mk_msg(input logic [7:0] s, input logic [7:0] a,
                                      input logic [7:0] b, input logic three);
    vme_msg_t m;
    m.status = s;
    m.d1 = a;
    m.d2 = b;
    m.three = three;
    return m;
  endfunction

  assign idx = voice[IDX_W-1:0];
  assign vok = ({1'b0, voice} < 5'(NUM_VOICES));
  assign perc_hi = perc_mode && (voice > 4'd5);
  assign perc_mid = perc_hi && (voice < 4'd10);
  assign ch = (voice == 4'd9) ? 4'd10 : voice;
  assign dsum = {1'b0, pending_delta} + {1'b0, delta_time};
  assign delta = dsum[VME_DELTA_W] ? '1 : dsum[VME_DELTA_W-1:0];
  assign held_rd = vok ? held_note[idx] : VME_NO_NOTE;
  assign level_rd = vok ? perc_level[idx] : 7'd0;

  always_comb begin
    if (!perc_hi) begin
      note_c = note;
    end else if (note < 7'd35) begin
      note_c = 7'd35;
    end else if (note > 7'd81) begin
      note_c = 7'd81;
    end else begin
      note_c = note;
    end
  end

  assign vol = amount[15] ? 7'd0 : ((|amount[14:7]) ? 7'd127 : amount[6:0]);
  assign pan_p = {~pan_value[7], pan_value[6:1]};

  always_comb begin
    if (amount[15] && !(&amount[14:7])) begin
      pitch_u = 8'd0;
    end else if (!amount[15] && (|amount[14:7])) begin
      pitch_u = 8'd255;
    end else begin
      pitch_u = {~amount[7], amount[6:0]};
    end
  end

  assign key_s = perc_hi ? 8'h99 : {4'h9, ch};
  assign ctrl_s = {4'hB, ch};

  always_comb begin
    desc = '0;
    desc.delta = delta;
    nmsg = 2'd0;
    held_we = 1'b0;
    held_wval = VME_NO_NOTE;
    level_we = 1'b0;
    mode_we = 1'b0;
    unique case (vme_op_e'(op))
      OP_KEY_ON: begin
        if (vok) begin
          held_we = 1'b1;
          held_wval = {1'b0, note_c};
          if (held_rd != VME_NO_NOTE) begin
            desc.msg[0] = mk_msg(key_s, held_rd, 8'd0, 1'b1);
            desc.msg[1] = mk_msg(key_s, {1'b0, note_c},
                                 perc_hi ? {1'b0, level_rd} : 8'd127, 1'b1);
            nmsg = 2'd2;
          end else begin
            desc.msg[0] = mk_msg(key_s, {1'b0, note_c},
                                 perc_hi ? {1'b0, level_rd} : 8'd127, 1'b1);
            nmsg = 2'd1;
          end
        end
      end
      OP_KEY_OFF: begin
        if (vok) begin
          held_we = 1'b1;
          desc.msg[0] = mk_msg(key_s, held_rd, 8'd0, 1'b1);
          nmsg = 2'd1;
        end
      end
      OP_VOLUME: begin
        if (vok) begin
          if (perc_mid) begin
            level_we = 1'b1;
          end else begin
            desc.msg[0] = mk_msg(ctrl_s, 8'd7, {1'b0, vol}, 1'b1);
            nmsg = 2'd1;
          end
        end
      end
      OP_PAN: begin
        if (vok) begin
          desc.msg[0] = mk_msg(perc_hi ? 8'hB9 : ctrl_s, 8'd10, {1'b0, pan_p}, 1'b1);
          nmsg = 2'd1;
        end
      end
      OP_INSTRUMENT: begin
        if (vok && !perc_hi) begin
          desc.msg[0] = mk_msg(ctrl_s, 8'd0, 8'd0, 1'b1);
          desc.msg[1] = mk_msg(ctrl_s, 8'h20, bank, 1'b1);
          desc.msg[2] = mk_msg({4'hC, ch}, {1'b0, program_req}, 8'd0, 1'b0);
          nmsg = 2'd3;
        end
      end
      OP_PITCH: begin
        if (vok && !perc_mid) begin
          desc.msg[0] = mk_msg({4'hE, ch}, {1'b0, pitch_u[0], 6'd0},
                               {1'b0, pitch_u[7:1]}, 1'b1);
          nmsg = 2'd1;
        end
      end
      OP_DRUMSET: begin
        if (perc_mode) begin
          desc.msg[0] = mk_msg(8'hB9, 8'd0, {1'b0, bank[6:0]}, 1'b1);
          nmsg = 2'd1;
        end
      end
      OP_PERC_MODE: begin
        mode_we = 1'b1;
      end
    endcase
    desc.nmsg_m1 = nmsg - 2'd1;
  end

  assign push = accept && (nmsg != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        held_note[i] <= VME_NO_NOTE;
        perc_level[i] <= 7'd0;
      end
      perc_mode <= 1'b0;
      pending_delta <= '0;
      default_level <= VME_DEFAULT_LEVEL;
    end else begin
      if (cfg_wr_en) begin
        default_level <= cfg_wr_data;
      end
      if (accept) begin
        pending_delta <= (nmsg == 2'd0) ? delta : '0;
        if (held_we) begin
          held_note[idx] <= held_wval;
        end
        if (level_we) begin
          perc_level[idx] <= vol;
        end
        if (mode_we) begin
          perc_mode <= percussion_on;
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (i >= 6 && i <= 9) begin
              perc_level[i] <= default_level;
            end
          end
        end
      end
    end
  end

endmodule

/* src/vme_queue.sv */
// Short queue of message lists between the front end and the serializer.
module vme_queue import vme_pkg::*; #(
  parameter int DEPTH = VME_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vme_desc_t wdata,
  output logic      full,
  input  logic      pop,
  output vme_desc_t rdata,
  output logic      nonempty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vme_desc_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

/* src/vme_back.sv */
// Back end: writes each queued message list as delta and message bytes.
module vme_back import vme_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  vme_desc_t head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      last
);

  typedef enum logic [1:0] {S_VLQ, S_STAT, S_D1, S_D2} st_t;

  st_t                    st;
  logic [1:0]             grp;
  logic [1:0]             msg_idx;
  vme_msg_t               cur;
  logic [VME_DELTA_W-1:0] cur_delta;
  logic [1:0]             groups_m1;
  logic [1:0]             g;
  logic [6:0]             slice;
  logic [7:0]             byte_sel;
  logic                   msg_end;
  logic                   item_end;
  logic                   advance;

  assign cur = head.msg[msg_idx];
  assign cur_delta = (msg_idx == 2'd0) ? head.delta : '0;

  always_comb begin
    if (|cur_delta[27:21]) begin
      groups_m1 = 2'd3;
    end else if (|cur_delta[20:14]) begin
      groups_m1 = 2'd2;
    end else if (|cur_delta[13:7]) begin
      groups_m1 = 2'd1;
    end else begin
      groups_m1 = 2'd0;
    end
  end

  assign g = groups_m1 - grp;

  always_comb begin
    case (g)
      2'd3:    slice = cur_delta[27:21];
      2'd2:    slice = cur_delta[20:14];
      2'd1:    slice = cur_delta[13:7];
      default: slice = cur_delta[6:0];
    endcase
  end

  always_comb begin
    unique case (st)
      S_VLQ:  byte_sel = {(g != 2'd0), slice};
      S_STAT: byte_sel = cur.status;
      S_D1:   byte_sel = cur.d1;
      S_D2:   byte_sel = cur.d2;
    endcase
  end

  assign msg_end = (st == S_D2) || (st == S_D1 && !cur.three);
  assign item_end = msg_end && (msg_idx == head.nmsg_m1);
  assign advance = head_valid && (!out_valid || !out_stall);
  assign pop = advance && item_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_VLQ;
      grp <= 2'd0;
      msg_idx <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        out_byte <= byte_sel;
        last <= item_end;
        if (msg_end) begin
          st <= S_VLQ;
          msg_idx <= item_end ? 2'd0 : msg_idx + 2'd1;
        end else begin
          unique case (st)
            S_VLQ: begin
              if (grp == groups_m1) begin
                st <= S_STAT;
                grp <= 2'd0;
              end else begin
                grp <= grp + 2'd1;
              end
            end
            S_STAT:  st <= S_D1;
            S_D1:    st <= S_D2;
            S_D2:    st <= S_VLQ;
          endcase
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_mid_item_has_head: assert property (@(posedge clk) disable iff (rst)
    (st != S_VLQ || msg_idx != 2'd0 || grp != 2'd0) |-> head_valid)
    else $error("serializer mid item with empty queue");
  a_d2_three: assert property (@(posedge clk) disable iff (rst)
    (st == S_D2) |-> cur.three)
    else $error("second data byte on two-byte message");

endmodule

/* src/voice_to_midi_event_encoder_core.sv */
// Top level of the voice command to MIDI file event encoder.
// Input channel: one voice command per item (op, voice, note, amount, pan_value,
// bank, program_req, percussion_on, delta_time) on in_valid / in_stall.
// Output channel: one MIDI file byte per item on out_valid / out_stall, with
// last set on the final byte a command causes. Commands that write nothing give
// no bytes and fold their delta into the next command that writes.
// cfg_wr_en / cfg_wr_data load the percussion default level; the user must do
// so only while idle, which the block does not enforce. The front end updates
// voice state in the accept cycle and queues a list of up to three messages;
// the serializer sends one byte per cycle while out_stall is low, and a command
// writes 4 to 14 bytes (delta groups plus message bytes). Commands are taken
// every cycle while the QUEUE_DEPTH entry queue has room; in_stall is high when
// it is full. When out_stall is high the output byte holds and the queue fills.
// Reset clears held notes to none, levels to zero, percussion mode off, the
// carried delta to zero, the default level to 80 and empties the queue.
module voice_to_midi_event_encoder_core import vme_pkg::*; #(
  parameter int NUM_VOICES = VME_NUM_VOICES,
  parameter int QUEUE_DEPTH = VME_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [6:0]             cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             op,
  input  logic [3:0]             voice,
  input  logic [6:0]             note,
  input  logic signed [15:0]     amount,
  input  logic signed [7:0]      pan_value,
  input  logic [7:0]             bank,
  input  logic [6:0]             program_req,
  input  logic                   percussion_on,
  input  logic [VME_DELTA_W-1:0] delta_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   last
);

  logic      accept;
  logic      push;
  logic      pop;
  logic      full;
  logic      nonempty;
  vme_desc_t wdesc;
  vme_desc_t head;

  assign in_stall = full;
  assign accept = in_valid && !in_stall;

  vme_front #(.NUM_VOICES(NUM_VOICES)) u_front (
    .clk,
    .rst,
    .cfg_wr_en,
    .cfg_wr_data,
    .accept,
    .op,
    .voice,
    .note,
    .amount,
    .pan_value,
    .bank,
    .program_req,
    .percussion_on,
    .delta_time,
    .push,
    .desc (wdesc)
  );

  vme_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk,
    .rst,
    .push,
    .wdata (wdesc),
    .full,
    .pop,
    .rdata (head),
    .nonempty
  );

  vme_back u_back (
    .clk,
    .rst,
    .head,
    .head_valid (nonempty),
    .pop,
    .out_valid,
    .out_stall,
    .out_byte,
    .last
  );

endmodule
